@@ hdl/dda_pkg.sv @@
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants for the decimal digit analyzer: the controller
// state encoding, the command and status groups between controller and
// datapath, and the field widths.
// ----------------------------------------------------------------------------
package dda_pkg;

  // Default digit limit. A 32-bit magnitude never has more than ten digits.
  localparam int MAX_DIGITS_DEFAULT = 10;

  // Field widths of the input and result items.
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 4;
  localparam int REV_W   = 34;
  localparam int SUM_W   = 7;
  localparam int NIB_W   = 4;

  // Reciprocal of ten for a 32-bit dividend: q = (x * RECIP10) >> RECIP_SHIFT.
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // take a new input item
    logic step;     // extract and accumulate one digit
    logic capture;  // move the finished result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;     // no digit left to extract and none pending
  } status_t;

endpackage

@@ hdl/dda_ctrl.sv @@
// ----------------------------------------------------------------------------
// dda_ctrl
// Controller for the decimal digit analyzer. Sequences load, digit steps and
// result capture, and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module dda_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  dda_pkg::status_t status,
  output dda_pkg::cmd_t    cmd
);

  dda_pkg::state_t state;
  dda_pkg::state_t state_next;
  logic            out_valid_next;
  logic            out_free;

  // The output register can take a result when empty or being emptied.
  assign out_free = !out_valid || out_ready;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dda_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands. No item is taken while reset is held.
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.step    = 1'b0;
    cmd.capture = 1'b0;
    case (state)
      dda_pkg::ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = dda_pkg::ST_RUN;
        end
      end
      dda_pkg::ST_RUN: begin
        cmd.step = 1'b1;
        if (status.done) begin
          if (out_free) begin
            cmd.capture = 1'b1;
            state_next  = dda_pkg::ST_IDLE;
          end else begin
            state_next = dda_pkg::ST_FINISH;
          end
        end
      end
      dda_pkg::ST_FINISH: begin
        if (out_free) begin
          cmd.capture = 1'b1;
          state_next  = dda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dda_pkg::ST_IDLE;
      end
    endcase
  end

  // A captured result is valid until the consumer takes it.
  always_comb begin
    if (cmd.capture) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

@@ hdl/dda_datapath.sv @@
// ----------------------------------------------------------------------------
// dda_datapath
// Datapath for the decimal digit analyzer. A two-stage digit loop: the first
// stage divides the remaining magnitude by ten, the second folds the digit
// registered by the first stage into the reversed value, sum, count,
// selected digit and rebuilt magnitude. Holds the output register as well.
// ----------------------------------------------------------------------------
module dda_datapath #(
  parameter int MAX_DIGITS = dda_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  dda_pkg::cmd_t                    cmd,
  output dda_pkg::status_t                 status,
  input  logic signed [dda_pkg::VALUE_W-1:0] value,
  input  logic [dda_pkg::INDEX_W-1:0]      digit_index,
  output logic [dda_pkg::REV_W-1:0]        reversed,
  output logic                             is_palindrome,
  output logic [dda_pkg::SUM_W-1:0]        digit_sum,
  output logic [dda_pkg::NIB_W-1:0]        digit_count,
  output logic [dda_pkg::NIB_W-1:0]        selected_digit
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int EXT_W = 8;

  // Working registers.
  logic [dda_pkg::VALUE_W-1:0] rest;
  logic [dda_pkg::VALUE_W-1:0] used;
  logic [dda_pkg::VALUE_W-1:0] place;
  logic [dda_pkg::REV_W-1:0]   rev;
  logic [dda_pkg::SUM_W-1:0]   sum;
  logic [dda_pkg::NIB_W-1:0]   sel;
  logic [dda_pkg::NIB_W-1:0]   digit;
  logic [dda_pkg::INDEX_W-1:0] idx;
  logic [CNT_W-1:0]            ext_cnt;
  logic [CNT_W-1:0]            acc_cnt;
  logic                        neg;
  logic                        pend;

  logic [dda_pkg::VALUE_W-1:0]   raw;
  logic [dda_pkg::VALUE_W-1:0]   mag;
  logic [2*dda_pkg::VALUE_W-1:0] prod;
  logic [dda_pkg::VALUE_W-1:0]   quot;
  logic [dda_pkg::VALUE_W-1:0]   remd;
  logic [dda_pkg::NIB_W-1:0]     dig_new;
  logic                          extract;
  logic [EXT_W-1:0]              acc_ext;
  logic [dda_pkg::VALUE_W-1:0]   dig_term;

  // Magnitude of the signed input.
  assign raw = value;
  assign mag = raw[dda_pkg::VALUE_W-1] ? (dda_pkg::VALUE_W'(0) - raw) : raw;

  // Divide by ten through the reciprocal; the remainder is the next digit.
  assign prod    = {{dda_pkg::VALUE_W{1'b0}}, rest} * {{dda_pkg::VALUE_W{1'b0}}, dda_pkg::RECIP10};
  assign quot    = dda_pkg::VALUE_W'(prod >> dda_pkg::RECIP_SHIFT);
  assign remd    = rest - {quot[dda_pkg::VALUE_W-4:0], 3'b000} - {quot[dda_pkg::VALUE_W-2:0], 1'b0};
  assign dig_new = remd[dda_pkg::NIB_W-1:0];

  // Another digit is taken while the rest is nonzero and the limit allows.
  assign extract     = (rest != '0) && (ext_cnt < CNT_W'(MAX_DIGITS));
  assign status.done = !extract && !pend;

  // Position of the digit being folded in, widened for the index compare.
  assign acc_ext  = {{(EXT_W-CNT_W){1'b0}}, acc_cnt};
  assign dig_term = {{(dda_pkg::VALUE_W-dda_pkg::NIB_W){1'b0}}, digit} * place;

  // Pending flag for the second loop stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.load) begin
      pend <= 1'b0;
    end else if (cmd.step) begin
      pend <= extract;
    end
  end

  // Digit loop registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rest    <= mag;
      neg     <= raw[dda_pkg::VALUE_W-1];
      idx     <= digit_index;
      ext_cnt <= '0;
      acc_cnt <= '0;
      rev     <= '0;
      sum     <= '0;
      sel     <= '0;
      used    <= '0;
      place   <= dda_pkg::VALUE_W'(1);
    end else if (cmd.step) begin
      // First stage: split off the lowest digit.
      if (extract) begin
        rest    <= quot;
        digit   <= dig_new;
        ext_cnt <= ext_cnt + CNT_W'(1);
      end
      // Second stage: fold in the digit from the previous cycle.
      if (pend) begin
        rev     <= {rev[dda_pkg::REV_W-4:0], 3'b000} + {rev[dda_pkg::REV_W-2:0], 1'b0}
                   + {{(dda_pkg::REV_W-dda_pkg::NIB_W){1'b0}}, digit};
        sum     <= sum + {{(dda_pkg::SUM_W-dda_pkg::NIB_W){1'b0}}, digit};
        used    <= used + dig_term;
        place   <= {place[dda_pkg::VALUE_W-4:0], 3'b000} + {place[dda_pkg::VALUE_W-2:0], 1'b0};
        acc_cnt <= acc_cnt + CNT_W'(1);
        if (acc_ext == {{(EXT_W-dda_pkg::INDEX_W){1'b0}}, idx}) begin
          sel <= digit;
        end
      end
    end
  end

  // Output register; zero counts as one digit.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      reversed       <= rev;
      is_palindrome  <= !neg && (rev == {{(dda_pkg::REV_W-dda_pkg::VALUE_W){1'b0}}, used});
      digit_sum      <= sum;
      digit_count    <= (acc_cnt == '0) ? dda_pkg::NIB_W'(1) : acc_ext[dda_pkg::NIB_W-1:0];
      selected_digit <= sel;
    end
  end

endmodule

@@ hdl/decimal_digit_analyzer_core.sv @@
// ----------------------------------------------------------------------------
// decimal_digit_analyzer_core
// Splits the magnitude of a signed integer into decimal digits and returns
// the digit-reversed value, palindrome flag, digit sum, digit count and the
// digit at a chosen position.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   value, digit_index
//   output   out_valid / out_ready reversed, is_palindrome, digit_sum,
//                                  digit_count, selected_digit
//
// An item is loaded on acceptance and then passes through the two-stage
// digit loop, which splits off one digit per cycle through a reciprocal
// multiply, at most MAX_DIGITS digits in all; the result is then captured
// into the output register. Zero splits off no digit.
// Reset is synchronous, clears the controller and valid flags, and holds
// in_ready low.
// A result waits in the output register while out_ready is low; the next
// item is accepted meanwhile and holds in the finish state until the
// register is free.
// ----------------------------------------------------------------------------
module decimal_digit_analyzer_core #(
  parameter int MAX_DIGITS = dda_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [dda_pkg::VALUE_W-1:0] value,
  input  logic [dda_pkg::INDEX_W-1:0]        digit_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dda_pkg::REV_W-1:0]          reversed,
  output logic                               is_palindrome,
  output logic [dda_pkg::SUM_W-1:0]          digit_sum,
  output logic [dda_pkg::NIB_W-1:0]          digit_count,
  output logic [dda_pkg::NIB_W-1:0]          selected_digit
);

  dda_pkg::cmd_t    cmd;
  dda_pkg::status_t status;

  // Sequencing.
  dda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Digit loop and output register.
  dda_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .value          (value),
    .digit_index    (digit_index),
    .reversed       (reversed),
    .is_palindrome  (is_palindrome),
    .digit_sum      (digit_sum),
    .digit_count    (digit_count),
    .selected_digit (selected_digit)
  );

endmodule

@@ hdl/dda_checker.sv @@
// ----------------------------------------------------------------------------
// dda_checker
// Port-level checks for the decimal digit analyzer, bound to the top level.
// ----------------------------------------------------------------------------
module dda_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic signed [dda_pkg::VALUE_W-1:0] value,
  input logic [dda_pkg::INDEX_W-1:0]        digit_index,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [dda_pkg::REV_W-1:0]          reversed,
  input logic                               is_palindrome,
  input logic [dda_pkg::SUM_W-1:0]          digit_sum,
  input logic [dda_pkg::NIB_W-1:0]          digit_count,
  input logic [dda_pkg::NIB_W-1:0]          selected_digit
);

  // A stalled result item stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(reversed) && $stable(digit_sum)
      && $stable(digit_count) && $stable(selected_digit) && $stable(is_palindrome))
    else $error("result payload changed while stalled");

  // A result always reports between one and ten digits.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> digit_count != 4'd0 && digit_count <= 4'd10)
    else $error("digit count out of range");

  // The selected digit is decimal, and the sum is bounded by nine per digit.
  a_digit_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> selected_digit <= 4'd9
      && {1'b0, digit_sum} <= ({4'b0000, digit_count} * 8'd9))
    else $error("digit sum or selected digit out of bounds");

endmodule

bind decimal_digit_analyzer_core dda_checker u_dda_checker (.*);

@@ test/tb_decimal_digit_analyzer_core.sv @@
// ----------------------------------------------------------------------------
// tb_decimal_digit_analyzer_core
// Self-checking testbench for the decimal digit analyzer. A short table of
// directed items covers zero, the range extremes, the most negative value,
// palindromes and out-of-range digit indexes. It is followed by about two
// thousand random items drawn from several value classes. Every result is
// compared field by field with a typed-in or behaviorally predicted result,
// with random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_decimal_digit_analyzer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W            = dda_pkg::VALUE_W;
  localparam int INDEX_W            = dda_pkg::INDEX_W;
  localparam int REV_W              = dda_pkg::REV_W;
  localparam int SUM_W              = dda_pkg::SUM_W;
  localparam int NIB_W              = dda_pkg::NIB_W;
  localparam int MAX_DIGITS_DEFAULT = dda_pkg::MAX_DIGITS_DEFAULT;

  localparam int RANDOM_ITEMS = 2000;
  localparam int IDLE_LIMIT   = 5000;
  localparam int TAIL_CYCLES  = 40;
  localparam int NUM_ROWS     = 21;

  // One expected result item.
  typedef struct packed {
    logic [REV_W-1:0] reversed;
    logic             is_palindrome;
    logic [SUM_W-1:0] digit_sum;
    logic [NIB_W-1:0] digit_count;
    logic [NIB_W-1:0] selected_digit;
  } digit_report_t;

  // One directed item; the result is typed in only when known_result is set.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
    logic                      known_result;
    logic [REV_W-1:0]          reversed;
    logic                      is_palindrome;
    logic [SUM_W-1:0]          digit_sum;
    logic [NIB_W-1:0]          digit_count;
    logic [NIB_W-1:0]          selected_digit;
  } digit_case_t;

  localparam digit_case_t DIRECTED_CASES [NUM_ROWS] = '{
    '{32'sd0,            4'd0,  1'b1, 34'd0,          1'b1, 7'd0,  4'd1,  4'd0},
    '{32'sd0,            4'd15, 1'b1, 34'd0,          1'b1, 7'd0,  4'd1,  4'd0},
    '{32'sd2147483647,   4'd0,  1'b1, 34'd7463847412, 1'b0, 7'd46, 4'd10, 4'd7},
    '{-32'sd2147483647,  4'd9,  1'b1, 34'd7463847412, 1'b0, 7'd46, 4'd10, 4'd2},
    '{32'sh8000_0000,    4'd3,  1'b1, 34'd8463847412, 1'b0, 7'd47, 4'd10, 4'd3},
    '{32'sd1,            4'd0,  1'b1, 34'd1,          1'b1, 7'd1,  4'd1,  4'd1},
    '{32'sd1,            4'd1,  1'b1, 34'd1,          1'b1, 7'd1,  4'd1,  4'd0},
    '{-32'sd1,           4'd0,  1'b1, 34'd1,          1'b0, 7'd1,  4'd1,  4'd1},
    '{32'sd9,            4'd0,  1'b0, 34'd0,          1'b0, 7'd0,  4'd0,  4'd0},
    '{32'sd10,           4'd1,  1'b0, 34'd0,          1'b0, 7'd0,  4'd0,  4'd0},
    '{32'sd12321,        4'd2,  1'b0, 34'd0,          1'b0, 7'd0,  4'd0,  4'd0},
    '{-32'sd12321,       4'd2,  1'b0, 34'd0,          1'b0, 7'd0,  4'd0,  4'd0},
    '{32'sd1000000000,   4'd9,  1'b0, 34'd0,          1'b0, 7'd0,  4'd0,  4'd0},
    '{32'sd1000000000,   4'd10, 1'b0, 34'd0,          1'b0, 7'd0,  4'd0,  4'd0},
    '{32'sd999999999,    4'd8,  1'b0, 34'd0,          1'b0, 7'd0,  4'd0,  4'd0},
    '{32'sd2147447412,   4'd5,  1'b0, 34'd0,          1'b0, 7'd0,  4'd0,  4'd0},
    '{32'sd1234567890,   4'd15, 1'b0, 34'd0,          1'b0, 7'd0,  4'd0,  4'd0},
    '{32'sd2000000002,   4'd0,  1'b0, 34'd0,          1'b0, 7'd0,  4'd0,  4'd0},
    '{-32'sd2000000002,  4'd9,  1'b0, 34'd0,          1'b0, 7'd0,  4'd0,  4'd0},
    '{32'sd100,          4'd0,  1'b0, 34'd0,          1'b0, 7'd0,  4'd0,  4'd0},
    '{32'sd1999999999,   4'd4,  1'b0, 34'd0,          1'b0, 7'd0,  4'd0,  4'd0}
  };

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [VALUE_W-1:0] value;
  logic [INDEX_W-1:0]        digit_index;
  logic                      out_valid;
  logic                      out_ready;
  logic [REV_W-1:0]          reversed;
  logic                      is_palindrome;
  logic [SUM_W-1:0]          digit_sum;
  logic [NIB_W-1:0]          digit_count;
  logic [NIB_W-1:0]          selected_digit;

  digit_report_t pending_reports[$];
  int            error_count;
  int            idle_cycles;
  bit            calm_phase;

  decimal_digit_analyzer_core DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .value         (value),
    .digit_index   (digit_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .reversed      (reversed),
    .is_palindrome (is_palindrome),
    .digit_sum     (digit_sum),
    .digit_count   (digit_count),
    .selected_digit(selected_digit)
  );

  // Free-running clock, 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Splits the magnitude into digits, least significant first, and builds the
  // report that the block should return for this item.
  function automatic digit_report_t analyze_digits(logic signed [VALUE_W-1:0] v,
                                                   logic [INDEX_W-1:0] idx);
    logic [31:0]   mag;
    logic [31:0]   rest;
    logic [31:0]   rebuilt;
    logic [31:0]   place;
    logic [31:0]   digit;
    logic [63:0]   rev;
    logic [31:0]   total;
    logic [31:0]   count;
    logic [31:0]   picked;
    logic          negative;
    digit_report_t rpt;
    negative = v[VALUE_W-1];
    mag      = negative ? (32'd0 - v) : v;
    rest     = mag;
    rebuilt  = '0;
    place    = 32'd1;
    rev      = '0;
    total    = '0;
    count    = '0;
    picked   = '0;
    for (int i = 0; i < MAX_DIGITS_DEFAULT && rest != 0; i++) begin
      digit   = rest % 10;
      rev     = rev * 10 + digit;
      total   = total + digit;
      if (count == idx) begin
        picked = digit;
      end
      rebuilt = rebuilt + digit * place;
      place   = place * 10;
      count   = count + 1;
      rest    = rest / 10;
    end
    if (count == 0) begin
      count = 1;
    end
    rpt.reversed       = rev[REV_W-1:0];
    rpt.is_palindrome  = !negative && (rev == {32'd0, rebuilt});
    rpt.digit_sum      = total[SUM_W-1:0];
    rpt.digit_count    = count[NIB_W-1:0];
    rpt.selected_digit = picked[NIB_W-1:0];
    return rpt;
  endfunction

  // Idle lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Random palindrome of 1 to 10 digits that fits a positive 32-bit value.
  function automatic longint make_palindrome();
    int     len;
    int     digits [10];
    longint result;
    len = $urandom_range(1, 10);
    for (int i = 0; i < (len + 1) / 2; i++) begin
      digits[i]           = (i == 0 && len > 1) ? $urandom_range(1, 9) : $urandom_range(0, 9);
      digits[len - 1 - i] = digits[i];
    end
    result = 0;
    for (int i = 0; i < len; i++) begin
      result = result * 10 + digits[i];
    end
    if (result > 64'd2147483647) begin
      result = 64'd2147447412;
    end
    return result;
  endfunction

  // Random value drawn from one of several classes of digit patterns.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int     roll;
    int     ndig;
    longint lo;
    longint hi;
    longint mag;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      return $urandom;
    end
    if (roll < 50) begin
      // Random magnitude with a chosen number of digits.
      ndig = $urandom_range(1, 10);
      lo   = 1;
      for (int i = 1; i < ndig; i++) begin
        lo = lo * 10;
      end
      hi  = (ndig == 10) ? 64'd2147483647 : lo * 10 - 1;
      mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
    end else if (roll < 70) begin
      mag = make_palindrome();
      if ($urandom_range(0, 3) != 0) begin
        return VALUE_W'(mag);
      end
    end else if (roll < 80) begin
      // Powers of ten and their neighbors.
      mag = 1;
      ndig = $urandom_range(0, 9);
      for (int i = 0; i < ndig; i++) begin
        mag = mag * 10;
      end
      mag = mag + $urandom_range(0, 2) - 1;
    end else begin
      mag = $urandom_range(0, 99);
    end
    return VALUE_W'($urandom_range(0, 1) ? -mag : mag);
  endfunction

  task automatic idle_inputs(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Presents one item and waits for it to be accepted.
  task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic [INDEX_W-1:0] idx,
                           input digit_report_t want);
    in_valid    <= 1'b1;
    value       <= v;
    digit_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_reports.push_back(want);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      error_count++;
    end
  endtask

  // Stimulus: reset, directed table, random items, then drain.
  initial begin
    digit_case_t             row;
    digit_report_t           want;
    logic signed [VALUE_W-1:0] v;
    logic [INDEX_W-1:0]      idx;
    rst         = 1'b1;
    in_valid    = 1'b0;
    value       = '0;
    digit_index = '0;
    error_count = 0;
    calm_phase  = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed items.
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED_CASES[r];
      if (row.known_result) begin
        want = '{row.reversed, row.is_palindrome, row.digit_sum, row.digit_count,
                 row.selected_digit};
      end else begin
        want = analyze_digits(row.value, row.index);
      end
      idle_inputs(pick_gap());
      send_item(row.value, row.index, want);
    end

    // Random items, with a stretch of full-rate traffic every so often.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm_phase = ((n / 250) % 4) == 3;
      v   = pick_value();
      idx = INDEX_W'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 10));
      if (!calm_phase) begin
        idle_inputs(pick_gap());
      end
      send_item(v, idx, analyze_digits(v, idx));
    end
    in_valid   <= 1'b0;
    calm_phase = 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Output back-pressure: runs of ready and stall of random length.
  initial begin
    int run_left;
    out_ready = 1'b0;
    run_left  = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (calm_phase) begin
        out_ready <= 1'b1;
        run_left  = 0;
      end else if (run_left == 0) begin
        if ($urandom_range(0, 2) != 0) begin
          out_ready <= 1'b1;
          run_left  = $urandom_range(1, 12);
        end else begin
          out_ready <= 1'b0;
          run_left  = pick_gap() + 1;
        end
      end else begin
        run_left--;
      end
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    digit_report_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual reversed %0d", $realtime,
                 reversed);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("reversed", want.reversed, reversed);
        check_field("is_palindrome", want.is_palindrome, is_palindrome);
        check_field("digit_sum", want.digit_sum, digit_sum);
        check_field("digit_count", want.digit_count, digit_count);
        check_field("selected_digit", want.selected_digit, selected_digit);
      end
    end
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles", $realtime, IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule

@@ decimal_digit_analyzer_core.f @@
hdl/dda_pkg.sv
hdl/dda_ctrl.sv
hdl/dda_datapath.sv
hdl/decimal_digit_analyzer_core.sv
hdl/dda_checker.sv
test/tb_decimal_digit_analyzer_core.sv
